>>> hdl/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared constants, types and codes for the trigger suffix matcher.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int Entries   = 16;
  localparam int HistLen   = 3;
  localparam int CharBits  = 16;
  localparam int TrigMax   = 3;
  localparam int EntryBits = 4;
  localparam int LenBits   = 2;
  localparam int CountBits = $clog2(HistLen + 1);

  typedef logic [CharBits-1:0] char_t;

  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Control from the top level to the history.
  typedef struct packed {
    logic  push;
    logic  clear;
    char_t ch;
  } hist_ctrl_t;

  // History as it looks after the pending character is appended.
  // Element 0 is the newest character.
  typedef struct packed {
    char_t [HistLen-1:0]  chars;
    logic [CountBits-1:0] count;
  } hist_view_t;

  // Table write request.
  typedef struct packed {
    logic                 we;
    logic [EntryBits-1:0] index;
    logic [LenBits-1:0]   len;
    char_t [TrigMax-1:0]  chars;
  } tbl_wr_t;

endpackage

>>> hdl/tsm_history.sv
// ----------------------------------------------------------------------------
// tsm_history
// Holds the most recent typed characters and their count.
// ----------------------------------------------------------------------------
module tsm_history (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsm_pkg::hist_ctrl_t ctrl_i,
  output tsm_pkg::hist_view_t view_o
);

  tsm_pkg::char_t [tsm_pkg::HistLen-1:0] hist_q, hist_d;
  logic [tsm_pkg::CountBits-1:0]         count_q, count_d;

  always_comb begin
    hist_d[0] = ctrl_i.ch;
    for (int i = 1; i < tsm_pkg::HistLen; i++) begin
      hist_d[i] = hist_q[i-1];
    end
    if (count_q == tsm_pkg::CountBits'(tsm_pkg::HistLen)) begin
      count_d = count_q;
    end else begin
      count_d = count_q + tsm_pkg::CountBits'(1);
    end
  end

  assign view_o.chars = hist_d;
  assign view_o.count = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      count_q <= '0;
    end else if (ctrl_i.push) begin
      count_q <= count_d;
    end
  end

  // Slots beyond the count are compared, but their hits are ignored, so they need no clearing.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      hist_q <= hist_d;
    end
  end

endmodule

>>> hdl/tsm_table.sv
// ----------------------------------------------------------------------------
// tsm_table
// Trigger table storage with one parallel comparator per entry and length.
// ----------------------------------------------------------------------------
module tsm_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsm_pkg::tbl_wr_t    wr_i,
  input  tsm_pkg::hist_view_t view_i,
  output logic [tsm_pkg::TrigMax-1:0][tsm_pkg::Entries-1:0] hit_o
);

  logic [tsm_pkg::LenBits-1:0]          len_q   [tsm_pkg::Entries];
  tsm_pkg::char_t [tsm_pkg::TrigMax-1:0] chars_q [tsm_pkg::Entries];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < tsm_pkg::Entries; e++) begin
        len_q[e] <= '0;
      end
    end else if (wr_i.we) begin
      len_q[wr_i.index] <= wr_i.len;
    end
  end

  // A zero length marks an entry invalid, so the characters need no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      chars_q[wr_i.index] <= wr_i.chars;
    end
  end

  // Trigger character k (oldest first) of a length l+1 trigger lines up with
  // history slot l-k, where slot zero holds the newest character.
  always_comb begin
    for (int l = 0; l < tsm_pkg::TrigMax; l++) begin
      for (int e = 0; e < tsm_pkg::Entries; e++) begin
        hit_o[l][e] = (len_q[e] == tsm_pkg::LenBits'(l + 1));
        for (int k = 0; k <= l; k++) begin
          if (chars_q[e][k] != view_i.chars[l-k]) begin
            hit_o[l][e] = 1'b0;
          end
        end
      end
    end
  end

endmodule

>>> hdl/text_macro_suffix_matcher.sv
// ----------------------------------------------------------------------------
// text_macro_suffix_matcher
// Appends typed characters to a short history and reports the longest
// history suffix found in a loadable trigger table.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake               Payload
//   input     in          in_valid_i/in_stall_o   op, ch, entry_index, trigger_*
//   output    out         out_valid_o/out_stall_i matched, match_entry, erase_count
//
// Each item yields one result via the input and result registers; one item
// is taken per cycle unless the output stalls. The input-to-result path is
// the 16-entry, three-length compare followed by the priority select.
// Reset empties the history and invalidates all table entries.
// A stall on the output holds the result register and backs up into the
// input register; the input side keeps accepting while the output can drain.
module text_macro_suffix_matcher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [15:0]                   ch_i,
  input  logic [3:0]                    entry_index_i,
  input  logic [1:0]                    trigger_len_i,
  input  logic [15:0]                   trigger_first_i,
  input  logic [15:0]                   trigger_second_i,
  input  logic [15:0]                   trigger_third_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          matched_o,
  output logic [tsm_pkg::EntryBits-1:0] match_entry_o,
  output logic [1:0]                    erase_count_o
);

  logic                          in_valid_q;
  logic [1:0]                    op_q;
  tsm_pkg::char_t                ch_q;
  logic [3:0]                    index_q;
  logic [tsm_pkg::LenBits-1:0]   tlen_q;
  tsm_pkg::char_t [tsm_pkg::TrigMax-1:0] tchars_q;

  logic                          out_valid_q;
  logic                          matched_q, matched_d;
  logic [tsm_pkg::EntryBits-1:0] entry_q, entry_d;
  logic [1:0]                    erase_q, erase_d;

  logic out_ready;
  logic fire;
  logic in_take;
  logic is_char;
  logic is_load;
  logic is_clear;

  tsm_pkg::hist_ctrl_t hist_ctrl;
  tsm_pkg::hist_view_t hist_view;
  tsm_pkg::tbl_wr_t    tbl_wr;
  logic [tsm_pkg::TrigMax-1:0][tsm_pkg::Entries-1:0] hit;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q        <= op_i;
      ch_q        <= ch_i[tsm_pkg::CharBits-1:0];
      index_q     <= entry_index_i;
      tlen_q      <= trigger_len_i;
      tchars_q[0] <= trigger_first_i[tsm_pkg::CharBits-1:0];
      tchars_q[1] <= trigger_second_i[tsm_pkg::CharBits-1:0];
      tchars_q[2] <= trigger_third_i[tsm_pkg::CharBits-1:0];
    end
  end

  always_comb begin
    is_char  = 1'b0;
    is_load  = 1'b0;
    is_clear = 1'b0;
    unique case (tsm_pkg::op_e'(op_q))
      tsm_pkg::OP_CHAR:  is_char  = (ch_q != '0);
      tsm_pkg::OP_LOAD:  is_load  = 1'b1;
      tsm_pkg::OP_CLEAR: is_clear = 1'b1;
      default: ;
    endcase
  end

  assign tbl_wr.we    = fire && is_load && (32'(index_q) < tsm_pkg::Entries);
  assign tbl_wr.index = tsm_pkg::EntryBits'(index_q);
  assign tbl_wr.len   = tlen_q;
  assign tbl_wr.chars = tchars_q;

  assign hist_ctrl.push  = fire && is_char;
  assign hist_ctrl.clear = fire && (is_clear || matched_d);
  assign hist_ctrl.ch    = ch_q;

  tsm_history u_history (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (hist_ctrl),
    .view_o (hist_view)
  );

  tsm_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (tbl_wr),
    .view_i (hist_view),
    .hit_o  (hit)
  );

  // Longer suffixes are visited later and override shorter ones; within a
  // length the entries are visited from the top so the lowest index wins.
  always_comb begin
    matched_d = 1'b0;
    entry_d   = '0;
    erase_d   = '0;
    if (is_char) begin
      for (int l = 0; l < tsm_pkg::TrigMax; l++) begin
        if (l < int'(hist_view.count)) begin
          for (int e = tsm_pkg::Entries - 1; e >= 0; e--) begin
            if (hit[l][e]) begin
              matched_d = 1'b1;
              entry_d   = tsm_pkg::EntryBits'(e);
              erase_d   = 2'(l);
            end
          end
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      matched_q <= matched_d;
      entry_q   <= entry_d;
      erase_q   <= erase_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign matched_o     = matched_q;
  assign match_entry_o = entry_q;
  assign erase_count_o = erase_q;

endmodule
